FILE: sv/gha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Shared field widths, command and status codes, and the request and
// response item types of the allocator core.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned GenWidthDefault = 32;

  localparam int unsigned CmdW = 2;
  localparam int unsigned IdxW = 10;
  localparam int unsigned HGenW = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned LiveW = 11;

  typedef enum logic [CmdW-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_QUERY   = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALIVE = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [IdxW-1:0]  entity_index;
    logic [HGenW-1:0] entity_generation;
  } gha_req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdxW-1:0]  handle_index;
    logic [HGenW-1:0] handle_generation;
    logic [LiveW-1:0] live_count;
  } gha_rsp_t;

endpackage
`default_nettype wire

FILE: sv/generational_handle_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generational handle allocator core
// Creates, destroys and checks handles made of a slot index and a generation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Payload
// request   in         req_valid_i / req_ready_o   req_i (cmd, index, generation)
// response  out        rsp_valid_o / rsp_ready_i   rsp_o (status, handle, count)
//
// One item is taken per cycle while the response is not stalled. While it
// sits in the input register the slot table and free stack are read, so its
// response is registered as it leaves the input register.
// Reset clears counters and valid flags; items are taken right after reset.
// A stalled response holds the input register and all state updates.
// Freed slots are stacked together with their generation.
// ----------------------------------------------------------------------------
module generational_handle_allocator_core #(
  parameter int unsigned CAPACITY  = gha_pkg::CapacityDefault,
  parameter int unsigned GEN_WIDTH = gha_pkg::GenWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  gha_pkg::gha_req_t req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output gha_pkg::gha_rsp_t rsp_o
);

  import gha_pkg::*;

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned StkW  = SlotW + GEN_WIDTH;
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic            req_valid_q;
  gha_req_t        req_q;
  logic            rsp_valid_q;
  gha_rsp_t        rsp_q;
  gha_rsp_t        rsp_d;
  logic [CntW-1:0] free_top_q, free_top_d;
  logic [CntW-1:0] high_water_q, high_water_d;
  logic [CntW-1:0] alive_total_q, alive_total_d;
  logic [CntW-1:0] free_top_m1;

  logic accept;
  logic fire;

  logic [31:0]      in_idx_ext;
  logic [SlotW-1:0] in_slot;
  logic [31:0]      q_idx_ext;
  logic [SlotW-1:0] q_slot;

  logic [GEN_WIDTH:0]   tbl_rd;
  logic                 tbl_alive;
  logic [GEN_WIDTH-1:0] tbl_gen;
  logic                 tbl_we;
  logic [SlotW-1:0]     tbl_waddr;
  logic [GEN_WIDTH:0]   tbl_wdata;

  logic [StkW-1:0]      stk_rd;
  logic [SlotW-1:0]     stk_slot;
  logic [GEN_WIDTH-1:0] stk_gen;
  logic                 stk_we;
  logic [SlotW-1:0]     stk_waddr;
  logic [StkW-1:0]      stk_wdata;

  logic                 in_range;
  logic                 gen_hi_ok;
  logic                 current;
  logic                 got;
  logic [SlotW-1:0]     new_slot;
  logic [GEN_WIDTH-1:0] base_gen;
  logic [GEN_WIDTH-1:0] new_gen;
  logic [31:0]          slot_ext;
  logic [31:0]          live_ext;

  assign accept      = req_valid_i && req_ready_o;
  assign fire        = req_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !req_valid_q || fire;

  assign in_idx_ext = 32'(req_i.entity_index);
  assign in_slot    = in_idx_ext[SlotW-1:0];
  assign q_idx_ext  = 32'(req_q.entity_index);
  assign q_slot     = q_idx_ext[SlotW-1:0];

  assign tbl_alive = tbl_rd[GEN_WIDTH];
  assign tbl_gen   = tbl_rd[GEN_WIDTH-1:0];
  assign stk_slot  = stk_rd[StkW-1:GEN_WIDTH];
  assign stk_gen   = stk_rd[GEN_WIDTH-1:0];

  assign in_range  = q_idx_ext < 32'(high_water_q);
  assign gen_hi_ok = (req_q.entity_generation >> GEN_WIDTH) == '0;
  assign current   = (req_q.entity_generation != '0) && in_range && tbl_alive && gen_hi_ok
                     && (req_q.entity_generation[GEN_WIDTH-1:0] == tbl_gen);

  assign free_top_m1 = free_top_d - CntW'(1);

  gha_fwd_ram #(
    .Depth (CAPACITY),
    .Width (GEN_WIDTH + 1)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (in_slot),
    .rd_data_o (tbl_rd),
    .wr_en_i   (tbl_we),
    .wr_addr_i (tbl_waddr),
    .wr_data_i (tbl_wdata)
  );

  gha_fwd_ram #(
    .Depth (CAPACITY),
    .Width (StkW)
  ) u_free_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (free_top_m1[SlotW-1:0]),
    .rd_data_o (stk_rd),
    .wr_en_i   (stk_we),
    .wr_addr_i (stk_waddr),
    .wr_data_i (stk_wdata)
  );

  always_comb begin
    got      = 1'b0;
    new_slot = high_water_q[SlotW-1:0];
    base_gen = '0;
    if (free_top_q != '0) begin
      got      = 1'b1;
      new_slot = stk_slot;
      base_gen = stk_gen;
    end else if (high_water_q < CapCnt) begin
      got = 1'b1;
    end
    new_gen = base_gen + GEN_WIDTH'(1);
    if (new_gen == '0) begin
      new_gen = GEN_WIDTH'(1);
    end
    slot_ext = 32'(new_slot);
  end

  always_comb begin
    free_top_d    = free_top_q;
    high_water_d  = high_water_q;
    alive_total_d = alive_total_q;
    tbl_we        = 1'b0;
    tbl_waddr     = q_slot;
    tbl_wdata     = {1'b0, tbl_gen};
    stk_we        = 1'b0;
    stk_waddr     = free_top_q[SlotW-1:0];
    stk_wdata     = {q_slot, tbl_gen};
    rsp_d.status            = ST_NOT_ALIVE;
    rsp_d.handle_index      = req_q.entity_index;
    rsp_d.handle_generation = req_q.entity_generation;
    if (fire) begin
      case (req_q.cmd)
        CMD_CREATE: begin
          if (got) begin
            if (free_top_q != '0) begin
              free_top_d = free_top_q - CntW'(1);
            end else begin
              high_water_d = high_water_q + CntW'(1);
            end
            alive_total_d           = alive_total_q + CntW'(1);
            tbl_we                  = 1'b1;
            tbl_waddr               = new_slot;
            tbl_wdata               = {1'b1, new_gen};
            rsp_d.status            = ST_OK;
            rsp_d.handle_index      = slot_ext[IdxW-1:0];
            rsp_d.handle_generation = HGenW'(new_gen);
          end else begin
            rsp_d.status            = ST_FULL;
            rsp_d.handle_index      = '0;
            rsp_d.handle_generation = '0;
          end
        end
        CMD_DESTROY: begin
          if (current) begin
            tbl_we = 1'b1;
            if (free_top_q < CapCnt) begin
              stk_we     = 1'b1;
              free_top_d = free_top_q + CntW'(1);
            end
            if (alive_total_q != '0) begin
              alive_total_d = alive_total_q - CntW'(1);
            end
            rsp_d.status = ST_OK;
          end
        end
        CMD_QUERY: begin
          if (current) begin
            rsp_d.status = ST_OK;
          end
        end
        default: begin
          rsp_d.status = ST_NOT_ALIVE;
        end
      endcase
    end
    live_ext         = 32'(alive_total_d);
    rsp_d.live_count = live_ext[LiveW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q   <= 1'b0;
      rsp_valid_q   <= 1'b0;
      free_top_q    <= '0;
      high_water_q  <= '0;
      alive_total_q <= '0;
    end else begin
      if (accept) begin
        req_valid_q <= 1'b1;
      end else if (fire) begin
        req_valid_q <= 1'b0;
      end
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      free_top_q    <= free_top_d;
      high_water_q  <= high_water_d;
      alive_total_q <= alive_total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

FILE: sv/gha_fwd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Forwarding RAM
// One write port and one registered read port. A read that hits the address
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module gha_fwd_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_q;
  logic [Width-1:0] byp_data_q;
  logic             byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule
`default_nettype wire
